[src/wsfr_pkg.sv]
// Package for the WebSocket frame receiver: result item type, kind, opcode,
// reply and error codes, and the counter width. No dependencies.
package wsfr_pkg;

   // Width of the payload and message byte counters.
   localparam int COUNT_WIDTH = 32;
   localparam logic [63:0] COUNT_MASK = (64'd1 << COUNT_WIDTH) - 64'd1;

   localparam logic [31:0] MAX_SIZE_RESET = 32'd16777216;

   localparam logic [2:0] KIND_HEADER  = 3'd0;
   localparam logic [2:0] KIND_PAYLOAD = 3'd1;
   localparam logic [2:0] KIND_EMPTY   = 3'd2;
   localparam logic [2:0] KIND_ERROR   = 3'd3;
   localparam logic [2:0] KIND_HALTED  = 3'd4;

   localparam logic [3:0] OP_CONT  = 4'h0;
   localparam logic [3:0] OP_TEXT  = 4'h1;
   localparam logic [3:0] OP_BIN   = 4'h2;
   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;
   localparam logic [3:0] OP_PONG  = 4'hA;

   localparam logic [1:0] REPLY_NONE  = 2'd0;
   localparam logic [1:0] REPLY_PONG  = 2'd1;
   localparam logic [1:0] REPLY_CLOSE = 2'd2;

   localparam logic [3:0] ERR_NONE         = 4'd0;
   localparam logic [3:0] ERR_RSV          = 4'd1;
   localparam logic [3:0] ERR_MASKED       = 4'd2;
   localparam logic [3:0] ERR_LEN63        = 4'd3;
   localparam logic [3:0] ERR_TOO_LONG     = 4'd4;
   localparam logic [3:0] ERR_CTL_FRAG     = 4'd5;
   localparam logic [3:0] ERR_CTL_BIG      = 4'd6;
   localparam logic [3:0] ERR_DATA_IN_FRAG = 4'd7;
   localparam logic [3:0] ERR_STRAY_CONT   = 4'd8;
   localparam logic [3:0] ERR_BAD_OPCODE   = 4'd9;
   localparam logic [3:0] ERR_MSG_TOO_LONG = 4'd10;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] payload_byte;
      logic [3:0] frame_opcode;
      logic       deliver;
      logic       message_end;
      logic       frame_end;
      logic       echo;
      logic [1:0] reply;
      logic [3:0] error_code;
   } wsfr_result_type;

endpackage

[src/wsfr_parse.sv]
// Frame parser state and the per-byte decision logic of the receiver.
// Depends on wsfr_pkg for codes, counter width and the result type.
module wsfr_parse (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic [7:0]               data,
   input  logic                     csr_we,
   input  logic [31:0]              csr_data,
   output wsfr_pkg::wsfr_result_type result
);

   localparam logic [2:0] PH_HDR0    = 3'd0;
   localparam logic [2:0] PH_HDR1    = 3'd1;
   localparam logic [2:0] PH_EXT     = 3'd2;
   localparam logic [2:0] PH_PAYLOAD = 3'd3;
   localparam logic [2:0] PH_HALT    = 3'd4;

   localparam int CW = wsfr_pkg::COUNT_WIDTH;

   logic [2:0]    phase_ff, phase_in;
   logic [3:0]    ext_left_ff, ext_left_in;
   logic [63:0]   len_ff, len_in;
   logic [CW-1:0] pay_left_ff, pay_left_in;
   logic          fin_ff, fin_in;
   logic [3:0]    op_ff, op_in;
   logic          rsv_ff, rsv_in;
   logic          in_frag_ff, in_frag_in;
   logic          frag_text_ff, frag_text_in;
   logic [CW-1:0] frag_len_ff, frag_len_in;
   logic [1:0]    echo_cnt_ff, echo_cnt_in;
   logic [3:0]    pend_ff, pend_in;
   logic [31:0]   max_size_ff;

   logic [63:0]   eff_limit;
   logic [63:0]   len_ext;
   logic [63:0]   hdr_len;
   logic [63:0]   fin_len;
   logic          too_long;
   logic          msg_over;
   logic [3:0]    disp_err;
   logic          hdr_done;
   logic          do_finish;
   logic          fail_en;
   logic [3:0]    fail_code;
   logic          dlv;

   always_comb begin
      eff_limit = ({32'd0, max_size_ff} > wsfr_pkg::COUNT_MASK) ?
                  wsfr_pkg::COUNT_MASK : {32'd0, max_size_ff};
      len_ext   = {len_ff[55:0], data};
      hdr_len   = (phase_ff == PH_HDR1) ? {57'd0, data[6:0]} : len_ext;
      too_long  = hdr_len > eff_limit;
      // Only used once the frame length is known to be within the limit.
      msg_over  = ({1'b0, frag_len_ff} + {1'b0, hdr_len[CW-1:0]}) >
                  {1'b0, eff_limit[CW-1:0]};
      unique case (op_ff)
         wsfr_pkg::OP_TEXT, wsfr_pkg::OP_BIN: begin
            disp_err = in_frag_ff ? wsfr_pkg::ERR_DATA_IN_FRAG : wsfr_pkg::ERR_NONE;
         end
         wsfr_pkg::OP_CONT: begin
            if (!in_frag_ff) disp_err = wsfr_pkg::ERR_STRAY_CONT;
            else if (frag_text_ff && msg_over) disp_err = wsfr_pkg::ERR_MSG_TOO_LONG;
            else disp_err = wsfr_pkg::ERR_NONE;
         end
         wsfr_pkg::OP_CLOSE, wsfr_pkg::OP_PING, wsfr_pkg::OP_PONG: begin
            disp_err = wsfr_pkg::ERR_NONE;
         end
         default: disp_err = wsfr_pkg::ERR_BAD_OPCODE;
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      ext_left_in  = ext_left_ff;
      len_in       = len_ff;
      pay_left_in  = pay_left_ff;
      fin_in       = fin_ff;
      op_in        = op_ff;
      rsv_in       = rsv_ff;
      in_frag_in   = in_frag_ff;
      frag_text_in = frag_text_ff;
      frag_len_in  = frag_len_ff;
      echo_cnt_in  = echo_cnt_ff;
      pend_in      = pend_ff;
      result       = '0;
      hdr_done     = 1'b0;
      do_finish    = 1'b0;
      fail_en      = 1'b0;
      fail_code    = wsfr_pkg::ERR_NONE;
      fin_len      = len_ff;
      dlv          = 1'b0;

      unique case (phase_ff)
         PH_HDR0: begin
            fin_in              = data[7];
            rsv_in              = |data[6:4];
            op_in               = data[3:0];
            pend_in             = wsfr_pkg::ERR_NONE;
            len_in              = 64'd0;
            phase_in            = PH_HDR1;
            result.kind         = wsfr_pkg::KIND_HEADER;
            result.frame_opcode = data[3:0];
         end
         PH_HDR1: begin
            if (rsv_ff) begin
               fail_en   = 1'b1;
               fail_code = wsfr_pkg::ERR_RSV;
            end else if (data[7]) begin
               fail_en   = 1'b1;
               fail_code = wsfr_pkg::ERR_MASKED;
            end else if (data[6:1] == 6'h3F) begin
               // Length codes 126 and 127 announce a 16-bit or 64-bit length.
               len_in              = 64'd0;
               ext_left_in         = data[0] ? 4'd8 : 4'd2;
               phase_in            = PH_EXT;
               result.kind         = wsfr_pkg::KIND_HEADER;
               result.frame_opcode = op_ff;
            end else begin
               hdr_done = 1'b1;
            end
         end
         PH_EXT: begin
            len_in      = len_ext;
            ext_left_in = ext_left_ff - 4'd1;
            if (ext_left_ff == 4'd8 && data[7]) pend_in = wsfr_pkg::ERR_LEN63;
            if (ext_left_in != 4'd0) begin
               result.kind         = wsfr_pkg::KIND_HEADER;
               result.frame_opcode = op_ff;
            end else if (pend_in == wsfr_pkg::ERR_LEN63) begin
               fail_en   = 1'b1;
               fail_code = wsfr_pkg::ERR_LEN63;
            end else begin
               hdr_done = 1'b1;
            end
         end
         PH_PAYLOAD: begin
            dlv = (pend_ff == wsfr_pkg::ERR_NONE) &&
                  (op_ff == wsfr_pkg::OP_TEXT ||
                   (op_ff == wsfr_pkg::OP_CONT && frag_text_ff));
            if (pend_ff == wsfr_pkg::ERR_NONE) begin
               if (op_ff == wsfr_pkg::OP_PING) begin
                  result.echo = 1'b1;
               end else if (op_ff == wsfr_pkg::OP_CLOSE && echo_cnt_ff < 2'd2) begin
                  result.echo = 1'b1;
                  echo_cnt_in = echo_cnt_ff + 2'd1;
               end
            end
            pay_left_in         = pay_left_ff - {{(CW-1){1'b0}}, 1'b1};
            result.kind         = wsfr_pkg::KIND_PAYLOAD;
            result.payload_byte = data;
            result.frame_opcode = op_ff;
            result.deliver      = dlv;
            if (pay_left_in == '0) begin
               if (pend_ff != wsfr_pkg::ERR_NONE) begin
                  fail_en   = 1'b1;
                  fail_code = pend_ff;
               end else begin
                  do_finish          = 1'b1;
                  fin_len            = len_ff;
                  result.message_end = dlv && fin_ff;
                  result.frame_end   = 1'b1;
               end
            end
         end
         default: begin
            phase_in    = PH_HALT;
            result.kind = wsfr_pkg::KIND_HALTED;
         end
      endcase

      if (hdr_done) begin
         len_in = hdr_len;
         if (too_long) begin
            fail_en   = 1'b1;
            fail_code = wsfr_pkg::ERR_TOO_LONG;
         end else if (op_ff[3] && !fin_ff) begin
            fail_en   = 1'b1;
            fail_code = wsfr_pkg::ERR_CTL_FRAG;
         end else if (op_ff[3] && hdr_len > 64'd125) begin
            fail_en   = 1'b1;
            fail_code = wsfr_pkg::ERR_CTL_BIG;
         end else begin
            pend_in     = disp_err;
            pay_left_in = hdr_len[CW-1:0];
            echo_cnt_in = 2'd0;
            if (hdr_len[CW-1:0] != '0) begin
               phase_in            = PH_PAYLOAD;
               result.kind         = wsfr_pkg::KIND_HEADER;
               result.frame_opcode = op_ff;
            end else if (disp_err != wsfr_pkg::ERR_NONE) begin
               fail_en   = 1'b1;
               fail_code = disp_err;
            end else begin
               dlv = op_ff == wsfr_pkg::OP_TEXT ||
                     (op_ff == wsfr_pkg::OP_CONT && frag_text_ff);
               do_finish           = 1'b1;
               fin_len             = hdr_len;
               result.kind         = wsfr_pkg::KIND_EMPTY;
               result.frame_opcode = op_ff;
               result.deliver      = dlv;
               result.message_end  = dlv && fin_ff;
               result.frame_end    = 1'b1;
            end
         end
      end

      // End of a frame: update the fragmentation state and pick a reply.
      if (do_finish) begin
         phase_in = PH_HDR0;
         unique case (op_ff)
            wsfr_pkg::OP_TEXT: begin
               if (!fin_ff) begin
                  in_frag_in   = 1'b1;
                  frag_text_in = 1'b1;
                  frag_len_in  = fin_len[CW-1:0];
               end
            end
            wsfr_pkg::OP_BIN: begin
               if (!fin_ff) begin
                  in_frag_in   = 1'b1;
                  frag_text_in = 1'b0;
                  frag_len_in  = '0;
               end
            end
            wsfr_pkg::OP_CONT: begin
               if (frag_text_ff) frag_len_in = frag_len_ff + fin_len[CW-1:0];
               if (fin_ff) begin
                  in_frag_in  = 1'b0;
                  frag_len_in = '0;
               end
            end
            wsfr_pkg::OP_CLOSE: begin
               result.reply = wsfr_pkg::REPLY_CLOSE;
               phase_in     = PH_HALT;
            end
            wsfr_pkg::OP_PING: begin
               result.reply = wsfr_pkg::REPLY_PONG;
            end
            default: begin
            end
         endcase
      end

      if (fail_en) begin
         phase_in            = PH_HALT;
         result              = '0;
         result.kind         = wsfr_pkg::KIND_ERROR;
         result.frame_opcode = op_ff;
         result.error_code   = fail_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR0;
         ext_left_ff  <= 4'd0;
         len_ff       <= 64'd0;
         pay_left_ff  <= '0;
         fin_ff       <= 1'b0;
         op_ff        <= wsfr_pkg::OP_CONT;
         rsv_ff       <= 1'b0;
         in_frag_ff   <= 1'b0;
         frag_text_ff <= 1'b0;
         frag_len_ff  <= '0;
         echo_cnt_ff  <= 2'd0;
         pend_ff      <= wsfr_pkg::ERR_NONE;
         max_size_ff  <= wsfr_pkg::MAX_SIZE_RESET;
      end else begin
         if (csr_we) max_size_ff <= csr_data;
         if (step) begin
            phase_ff     <= phase_in;
            ext_left_ff  <= ext_left_in;
            len_ff       <= len_in;
            pay_left_ff  <= pay_left_in;
            fin_ff       <= fin_in;
            op_ff        <= op_in;
            rsv_ff       <= rsv_in;
            in_frag_ff   <= in_frag_in;
            frag_text_ff <= frag_text_in;
            frag_len_ff  <= frag_len_in;
            echo_cnt_ff  <= echo_cnt_in;
            pend_ff      <= pend_in;
         end
      end
   end

endmodule

[src/websocket_frame_receiver_top.sv]
// Top level of the WebSocket frame receiver: input byte register, result
// register and handshakes around wsfr_parse. Depends on wsfr_pkg.
//
//   channel | direction | handshake          | payload
//   req_    | in        | req_valid/req_stall | req_data (one received byte)
//   rsp_    | out       | rsp_valid/rsp_stall | rsp_kind ... rsp_error_code
//   csr_    | in        | csr_valid/csr_ready | csr_data (max_message_size)
//
// A byte's result item enters the result register as the byte leaves the input
// register, and a new byte is taken every cycle unless rsp_ stalls; the throughput
// is set by the single parse stage between the input and the result register.
// Reset is synchronous and active high and returns the parser to the first
// header byte with the size limit at 16 MiB. A stalled result holds the
// result register, which in turn holds the input register and stalls req_.
module websocket_frame_receiver_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [3:0]  rsp_frame_opcode,
   output logic        rsp_deliver,
   output logic        rsp_message_end,
   output logic        rsp_frame_end,
   output logic        rsp_echo,
   output logic [1:0]  rsp_reply,
   output logic [3:0]  rsp_error_code,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   logic                      in_valid_ff, in_valid_in;
   logic [7:0]                in_data_ff;
   logic                      out_valid_ff, out_valid_in;
   wsfr_pkg::wsfr_result_type out_res_ff;
   wsfr_pkg::wsfr_result_type parse_res;
   logic                      advance;
   logic                      req_take;

   assign csr_ready = 1'b1;
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   wsfr_parse u_parse (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .data     (in_data_ff),
      .csr_we   (csr_valid && csr_ready),
      .csr_data (csr_data),
      .result   (parse_res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
      out_valid_in = out_valid_ff;
      if (advance) out_valid_in = 1'b1;
      else if (!rsp_stall) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) in_data_ff <= req_data;
      if (advance) out_res_ff <= parse_res;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_res_ff.kind;
   assign rsp_payload_byte = out_res_ff.payload_byte;
   assign rsp_frame_opcode = out_res_ff.frame_opcode;
   assign rsp_deliver      = out_res_ff.deliver;
   assign rsp_message_end  = out_res_ff.message_end;
   assign rsp_frame_end    = out_res_ff.frame_end;
   assign rsp_echo         = out_res_ff.echo;
   assign rsp_reply        = out_res_ff.reply;
   assign rsp_error_code   = out_res_ff.error_code;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !in_valid_ff)
      else $error("pipeline not empty after reset");

   a_error_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == wsfr_pkg::KIND_ERROR |->
         rsp_error_code != wsfr_pkg::ERR_NONE && !rsp_frame_end && !rsp_deliver)
      else $error("error item carries bad fields");

   a_echo_ctl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_echo |->
         rsp_frame_opcode == wsfr_pkg::OP_PING || rsp_frame_opcode == wsfr_pkg::OP_CLOSE)
      else $error("echo outside a ping or close frame");

   a_msg_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_message_end |-> rsp_deliver && rsp_frame_end)
      else $error("message end without delivered frame end");

endmodule

[sim/tb_websocket_frame_receiver_top.sv]
// Self-checking testbench for websocket_frame_receiver_top: byte driver, result monitor
// and a byte-level frame parser that predicts every result item.
// Depends on wsfr_pkg and the receiver RTL.
module tb_websocket_frame_receiver_top;
   import wsfr_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;
   localparam int CTL_MAX_LEN = 125;

   typedef enum logic [2:0] {RX_HDR0, RX_HDR1, RX_EXT, RX_PAYLOAD, RX_HALT} rx_phase_type;
   typedef enum logic [1:0] {ACT_BYTE, ACT_LIMIT, ACT_DRAIN} stim_act_type;
   typedef struct packed {
      stim_act_type act;
      logic [31:0]  value;
   } stim_entry_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_payload_byte;
   logic [3:0]  rsp_frame_opcode;
   logic        rsp_deliver;
   logic        rsp_message_end;
   logic        rsp_frame_end;
   logic        rsp_echo;
   logic [1:0]  rsp_reply;
   logic [3:0]  rsp_error_code;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data = 32'd0;

   websocket_frame_receiver_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_kind         (rsp_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_frame_opcode (rsp_frame_opcode),
      .rsp_deliver      (rsp_deliver),
      .rsp_message_end  (rsp_message_end),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_echo         (rsp_echo),
      .rsp_reply        (rsp_reply),
      .rsp_error_code   (rsp_error_code),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data)
   );

   always #1 clock = ~clock;

   // Parser state, as it stands after reset.
   rx_phase_type rx_phase = RX_HDR0;
   logic [3:0]  ext_left = 4'd0;
   logic [63:0] frame_len = 64'd0;
   logic [63:0] payload_left = 64'd0;
   logic        hdr_fin = 1'b0;
   logic [3:0]  cur_op = OP_CONT;
   logic        rsv_bad = 1'b0;
   logic        in_frag = 1'b0;
   logic        frag_text = 1'b0;
   logic [63:0] frag_len = 64'd0;
   logic [1:0]  close_echo_cnt = 2'd0;
   logic [3:0]  pending_err = ERR_NONE;
   logic [31:0] size_limit = MAX_SIZE_RESET;

   wsfr_result_type results_due[$];
   stim_entry_type  byte_plan[$];

   int fail_count = 0;
   int bytes_sent = 0;
   int rsp_count = 0;
   int frames_closed = 0;
   int limit_writes = 0;
   int cycle_count = 0;
   int hold_left = 0;
   logic hold_done = 1'b0;
   logic [2:0] last_kind = KIND_HEADER;
   logic [3:0] last_err = ERR_NONE;

   // Stimulus planning state: tracks fragmentation so that most frames are well formed.
   logic [31:0] plan_limit = MAX_SIZE_RESET;
   logic        plan_in_frag = 1'b0;
   logic        plan_frag_text = 1'b0;
   int          plan_frag_len = 0;
   int          plan_bytes = 0;

   function automatic wsfr_result_type mk(input logic [2:0] kind, input logic [7:0] pb,
                                          input logic [3:0] op, input logic dlv,
                                          input logic mend, input logic fend,
                                          input logic echo, input logic [1:0] reply,
                                          input logic [3:0] err);
      wsfr_result_type r;
      r.kind = kind;
      r.payload_byte = pb;
      r.frame_opcode = op;
      r.deliver = dlv;
      r.message_end = mend;
      r.frame_end = fend;
      r.echo = echo;
      r.reply = reply;
      r.error_code = err;
      return r;
   endfunction

   function automatic logic [63:0] eff_limit();
      return ({32'd0, size_limit} < COUNT_MASK) ? {32'd0, size_limit} : COUNT_MASK;
   endfunction

   function automatic wsfr_result_type halt_on(input logic [3:0] err);
      rx_phase = RX_HALT;
      return mk(KIND_ERROR, 8'd0, cur_op, 1'b0, 1'b0, 1'b0, 1'b0, REPLY_NONE, err);
   endfunction

   function automatic logic text_delivered();
      return pending_err == ERR_NONE && (cur_op == OP_TEXT || (cur_op == OP_CONT && frag_text));
   endfunction

   // Applies what a completed frame does to the message state; gives the reply to send.
   function automatic logic [1:0] close_frame();
      logic [1:0] rep;
      rep = REPLY_NONE;
      rx_phase = RX_HDR0;
      case (cur_op)
         OP_TEXT: if (!hdr_fin) begin
            in_frag = 1'b1;
            frag_text = 1'b1;
            frag_len = frame_len & COUNT_MASK;
         end
         OP_BIN: if (!hdr_fin) begin
            in_frag = 1'b1;
            frag_text = 1'b0;
            frag_len = 64'd0;
         end
         OP_CONT: begin
            if (frag_text) frag_len = (frag_len + frame_len) & COUNT_MASK;
            if (hdr_fin) begin
               in_frag = 1'b0;
               frag_len = 64'd0;
            end
         end
         OP_CLOSE: begin
            rep = REPLY_CLOSE;
            rx_phase = RX_HALT;
         end
         OP_PING: rep = REPLY_PONG;
         default: ;
      endcase
      return rep;
   endfunction

   function automatic wsfr_result_type end_of_header();
      logic [63:0] lim;
      logic        d;
      logic [3:0]  op;
      logic [1:0]  rep;
      lim = eff_limit();
      if (frame_len > lim) return halt_on(ERR_TOO_LONG);
      if (cur_op[3]) begin
         if (!hdr_fin) return halt_on(ERR_CTL_FRAG);
         if (frame_len > CTL_MAX_LEN) return halt_on(ERR_CTL_BIG);
      end
      // Dispatch problems are held back until the frame's last byte.
      case (cur_op)
         OP_TEXT, OP_BIN: pending_err = in_frag ? ERR_DATA_IN_FRAG : ERR_NONE;
         OP_CONT: begin
            if (!in_frag) pending_err = ERR_STRAY_CONT;
            else if (frag_text && frag_len > lim - frame_len) pending_err = ERR_MSG_TOO_LONG;
            else pending_err = ERR_NONE;
         end
         OP_CLOSE, OP_PING, OP_PONG: pending_err = ERR_NONE;
         default: pending_err = ERR_BAD_OPCODE;
      endcase
      payload_left = frame_len & COUNT_MASK;
      close_echo_cnt = 2'd0;
      if (payload_left != 64'd0) begin
         rx_phase = RX_PAYLOAD;
         return mk(KIND_HEADER, 8'd0, cur_op, 1'b0, 1'b0, 1'b0, 1'b0, REPLY_NONE, ERR_NONE);
      end
      if (pending_err != ERR_NONE) return halt_on(pending_err);
      d = text_delivered();
      op = cur_op;
      rep = close_frame();
      return mk(KIND_EMPTY, 8'd0, op, d, d && hdr_fin, 1'b1, 1'b0, rep, ERR_NONE);
   endfunction

   function automatic wsfr_result_type parse_byte(input logic [7:0] b);
      logic       d;
      logic       echo;
      logic [3:0] op;
      logic [1:0] rep;
      case (rx_phase)
         RX_HDR0: begin
            hdr_fin = b[7];
            rsv_bad = b[6:4] != 3'd0;
            cur_op = b[3:0];
            pending_err = ERR_NONE;
            frame_len = 64'd0;
            rx_phase = RX_HDR1;
            return mk(KIND_HEADER, 8'd0, cur_op, 1'b0, 1'b0, 1'b0, 1'b0, REPLY_NONE, ERR_NONE);
         end
         RX_HDR1: begin
            if (rsv_bad) return halt_on(ERR_RSV);
            if (b[7]) return halt_on(ERR_MASKED);
            frame_len = 64'd0;
            if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
               ext_left = (b[6:0] == LEN_EXT16) ? 4'd2 : 4'd8;
               rx_phase = RX_EXT;
               return mk(KIND_HEADER, 8'd0, cur_op, 1'b0, 1'b0, 1'b0, 1'b0, REPLY_NONE,
                         ERR_NONE);
            end
            frame_len = {57'd0, b[6:0]};
            return end_of_header();
         end
         RX_EXT: begin
            if (ext_left == 4'd8 && b[7]) pending_err = ERR_LEN63;
            frame_len = {frame_len[55:0], b};
            ext_left = ext_left - 4'd1;
            if (ext_left != 4'd0)
               return mk(KIND_HEADER, 8'd0, cur_op, 1'b0, 1'b0, 1'b0, 1'b0, REPLY_NONE,
                         ERR_NONE);
            if (pending_err == ERR_LEN63) return halt_on(ERR_LEN63);
            return end_of_header();
         end
         RX_PAYLOAD: begin
            d = text_delivered();
            echo = 1'b0;
            if (pending_err == ERR_NONE) begin
               if (cur_op == OP_PING) echo = 1'b1;
               else if (cur_op == OP_CLOSE && close_echo_cnt < 2'd2) begin
                  echo = 1'b1;
                  close_echo_cnt = close_echo_cnt + 2'd1;
               end
            end
            payload_left = (payload_left - 64'd1) & COUNT_MASK;
            if (payload_left != 64'd0)
               return mk(KIND_PAYLOAD, b, cur_op, d, 1'b0, 1'b0, echo, REPLY_NONE, ERR_NONE);
            if (pending_err != ERR_NONE) return halt_on(pending_err);
            op = cur_op;
            rep = close_frame();
            return mk(KIND_PAYLOAD, b, op, d, d && hdr_fin, 1'b1, echo, rep, ERR_NONE);
         end
         default: begin
            rx_phase = RX_HALT;
            return mk(KIND_HALTED, 8'd0, OP_CONT, 1'b0, 1'b0, 1'b0, 1'b0, REPLY_NONE,
                      ERR_NONE);
         end
      endcase
   endfunction

   task automatic plan_add(input stim_act_type act, input logic [31:0] value);
      stim_entry_type e;
      e.act = act;
      e.value = value;
      byte_plan = {byte_plan, e};
   endtask

   task automatic push_byte(input logic [7:0] b);
      plan_add(ACT_BYTE, {24'd0, b});
      plan_bytes++;
   endtask

   // Frame with a random choice among the length encodings that can hold its length.
   task automatic push_frame(input logic fin, input logic [3:0] op, input int len);
      logic [63:0] l64;
      int pick;
      l64 = 64'(len);
      pick = $urandom_range(0, 9);
      push_byte({fin, 3'b000, op});
      if (len < 126 && pick < 8) begin
         push_byte({1'b0, l64[6:0]});
      end else if (pick[0]) begin
         push_byte({1'b0, LEN_EXT16});
         push_byte(l64[15:8]);
         push_byte(l64[7:0]);
      end else begin
         push_byte({1'b0, LEN_EXT64});
         for (int i = 7; i >= 0; i--) push_byte(l64[8*i +: 8]);
      end
      for (int i = 0; i < len; i++) push_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic close_open_fragment();
      if (plan_in_frag) push_frame(1'b1, OP_CONT, 0);
      plan_in_frag = 1'b0;
      plan_frag_len = 0;
   endtask

   task automatic push_limit(input logic [31:0] v);
      close_open_fragment();
      plan_add(ACT_LIMIT, v);
      plan_limit = v;
   endtask

   function automatic int pick_len(input int maxv);
      int r;
      r = $urandom_range(0, 99);
      if (maxv <= 0) return 0;
      if (r < 70) return $urandom_range(0, (maxv < 12) ? maxv : 12);
      if (r < 96) return $urandom_range(0, (maxv < 130) ? maxv : 130);
      return $urandom_range(0, (maxv < 300) ? maxv : 300);
   endfunction

   // One well-formed frame that respects the current size limit and the open message.
   task automatic plan_frame();
      int room;
      int ctl_room;
      int r;
      int len;
      logic fin;
      logic is_text;
      room = (plan_limit > 32'd1000) ? 1000 : plan_limit;
      ctl_room = (room < CTL_MAX_LEN) ? room : CTL_MAX_LEN;
      r = $urandom_range(0, 99);
      if (plan_in_frag) begin
         if (r < 60) begin
            fin = $urandom_range(0, 2) == 0;
            len = pick_len(plan_frag_text ? room - plan_frag_len : room);
            push_frame(fin, OP_CONT, len);
            if (plan_frag_text) plan_frag_len += len;
            if (fin) begin
               plan_in_frag = 1'b0;
               plan_frag_len = 0;
            end
         end else begin
            push_frame(1'b1, (r < 80) ? OP_PING : OP_PONG, pick_len(ctl_room));
         end
      end else if (r < 15) begin
         push_frame(1'b1, (r < 8) ? OP_PING : OP_PONG, pick_len(ctl_room));
      end else begin
         fin = $urandom_range(0, 99) < 65;
         is_text = r < 60;
         len = pick_len(room);
         push_frame(fin, is_text ? OP_TEXT : OP_BIN, len);
         if (!fin) begin
            plan_in_frag = 1'b1;
            plan_frag_text = is_text;
            plan_frag_len = is_text ? len : 0;
         end
      end
   endtask

   task automatic plan_stretch(input int n);
      int stop_at;
      stop_at = plan_bytes + n;
      while (plan_bytes < stop_at) begin
         plan_frame();
         if ($urandom_range(0, 49) == 0) plan_add(ACT_DRAIN, 32'd0);
      end
   endtask

   // The stream ends in one event that halts the parser, then a few ignored bytes.
   task automatic plan_ending();
      logic [7:0] hb;
      logic [3:0] op;
      int k;
      close_open_fragment();
      case ($urandom_range(0, 10))
         0: begin
            hb = 8'($urandom_range(0, 255));
            hb[6:4] = 3'($urandom_range(1, 7));
            push_byte(hb);
            push_byte(8'($urandom_range(0, 255)));
         end
         1: begin
            push_byte({1'b1, 3'b000, OP_BIN});
            hb = 8'($urandom_range(0, 255));
            push_byte(hb | 8'h80);
         end
         2: begin
            push_byte({1'b1, 3'b000, OP_TEXT});
            push_byte({1'b0, LEN_EXT64});
            hb = 8'($urandom_range(0, 255));
            push_byte(hb | 8'h80);
            for (int i = 0; i < 7; i++) push_byte(8'($urandom_range(0, 255)));
         end
         3: begin
            // A length above any 32-bit limit.
            push_byte({1'b1, 3'b000, OP_BIN});
            push_byte({1'b0, LEN_EXT64});
            push_byte(8'h00);
            push_byte(8'h00);
            push_byte(8'h00);
            push_byte(8'h01);
            for (int i = 0; i < 4; i++) push_byte(8'($urandom_range(0, 255)));
         end
         4: begin
            op = $urandom_range(0, 1) ? OP_PING : OP_PONG;
            push_byte({1'b0, 3'b000, op});
            push_byte(8'h00);
         end
         5: begin
            push_byte({1'b1, 3'b000, OP_PING});
            push_byte({1'b0, LEN_EXT16});
            push_byte(8'h00);
            push_byte(8'($urandom_range(126, 255)));
         end
         6: begin
            push_frame(1'b0, OP_TEXT, $urandom_range(1, 4));
            push_frame(1'b1, $urandom_range(0, 1) ? OP_BIN : OP_TEXT, $urandom_range(0, 3));
         end
         7: push_frame(1'($urandom_range(0, 1)), OP_CONT, $urandom_range(0, 3));
         8: begin
            op = $urandom_range(0, 1) ? 4'($urandom_range(3, 7)) : 4'($urandom_range(11, 15));
            push_frame(1'b1, op, $urandom_range(0, 3));
         end
         9: begin
            k = $urandom_range(1, 8);
            push_limit(k);
            push_frame(1'b0, OP_TEXT, k);
            push_frame(1'b1, OP_CONT, $urandom_range(1, k));
         end
         default: push_frame(1'b1, OP_CLOSE, $urandom_range(0, 4));
      endcase
      for (int i = 0; i < 8; i++) push_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin : drive_bytes
      stim_entry_type  head;
      wsfr_result_type due;
      logic            nxt_valid;
      logic            nxt_csr_valid;
      logic            idle_now;
      logic [7:0]      nxt_data;
      logic [31:0]     nxt_csr_data;
      if (reset) begin
         req_valid <= 1'b0;
         csr_valid <= 1'b0;
      end else begin
         nxt_valid = req_valid;
         nxt_data = req_data;
         nxt_csr_valid = csr_valid;
         nxt_csr_data = csr_data;
         if (csr_valid && csr_ready) begin
            size_limit = csr_data;
            limit_writes++;
            nxt_csr_valid = 1'b0;
            head = byte_plan.pop_front();
         end
         if (req_valid && !req_stall) begin
            due = parse_byte(req_data);
            results_due = {results_due, due};
            bytes_sent++;
            nxt_valid = 1'b0;
         end
         if (!nxt_csr_valid && !(req_valid && req_stall) && byte_plan.size() != 0) begin
            head = byte_plan[0];
            idle_now = ($urandom_range(0, 99) < 13) && !(bytes_sent >= 500 && bytes_sent < 800);
            case (head.act)
               ACT_BYTE: if (!idle_now) begin
                  nxt_valid = 1'b1;
                  nxt_data = head.value[7:0];
                  head = byte_plan.pop_front();
               end
               ACT_DRAIN: if (results_due.size() == 0) head = byte_plan.pop_front();
               default: if (results_due.size() == 0) begin
                  // The limit is only changed with nothing left inside the block.
                  nxt_csr_valid = 1'b1;
                  nxt_csr_data = head.value;
               end
            endcase
         end
         req_valid <= nxt_valid;
         req_data <= nxt_data;
         csr_valid <= nxt_csr_valid;
         csr_data <= nxt_csr_data;
      end
   end

   always @(posedge clock) begin : watch_results
      wsfr_result_type got;
      wsfr_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = mk(rsp_kind, rsp_payload_byte, rsp_frame_opcode, rsp_deliver, rsp_message_end,
                     rsp_frame_end, rsp_echo, rsp_reply, rsp_error_code);
            rsp_count++;
            last_kind = got.kind;
            last_err = got.error_code;
            if (got.frame_end) frames_closed++;
            if (results_due.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result, expected none, actual kind %0d",
                        $time, got.kind);
            end else begin
               want = results_due.pop_front();
               check_field("kind", 8'(want.kind), 8'(got.kind));
               check_field("payload_byte", want.payload_byte, got.payload_byte);
               check_field("frame_opcode", 8'(want.frame_opcode), 8'(got.frame_opcode));
               check_field("deliver", 8'(want.deliver), 8'(got.deliver));
               check_field("message_end", 8'(want.message_end), 8'(got.message_end));
               check_field("frame_end", 8'(want.frame_end), 8'(got.frame_end));
               check_field("echo", 8'(want.echo), 8'(got.echo));
               check_field("reply", 8'(want.reply), 8'(got.reply));
               check_field("error_code", 8'(want.error_code), 8'(got.error_code));
            end
         end
         // One long hold-off fills the block so that it has to stall its input.
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && rsp_count >= 250) begin
            hold_done = 1'b1;
            hold_left = 100;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 13) && !(rsp_count >= 500 && rsp_count < 800);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, results_due.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      // Directed opening: empty text message, one-byte binary frame with the top byte
      // value, a text fragment with a 16-bit length, a ping between fragments, and the
      // closing continuation with a 64-bit length.
      push_byte({1'b1, 3'b000, OP_TEXT});
      push_byte(8'h00);
      push_byte({1'b1, 3'b000, OP_BIN});
      push_byte(8'h01);
      push_byte(8'hFF);
      push_byte({1'b0, 3'b000, OP_TEXT});
      push_byte({1'b0, LEN_EXT16});
      push_byte(8'h00);
      push_byte(8'h01);
      push_byte(8'h41);
      push_byte({1'b1, 3'b000, OP_PING});
      push_byte(8'h01);
      push_byte(8'h00);
      push_byte({1'b1, 3'b000, OP_CONT});
      push_byte({1'b0, LEN_EXT64});
      for (int i = 0; i < 7; i++) push_byte(8'h00);
      push_byte(8'h01);
      push_byte(8'h7A);
      plan_add(ACT_DRAIN, 32'd0);

      plan_stretch(320);
      push_limit(32'd0);
      plan_stretch(80);
      push_limit(32'hFFFF_FFFF);
      plan_stretch(300);
      push_limit($urandom_range(1, 200));
      plan_stretch(300);
      push_limit($urandom());
      plan_stretch(200);
      push_limit($urandom() | 32'h0100_0000);
      plan_ending();

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      while (byte_plan.size() != 0 || req_valid || csr_valid || results_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      $display("Sent %0d bytes with %0d size-limit writes; %0d results, %0d frames closed.",
               bytes_sent, limit_writes, rsp_count, frames_closed);
      $display("The stream ended in result kind %0d with error code %0d.", last_kind, last_err);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[websocket_frame_receiver_top.f]
src/wsfr_pkg.sv
src/wsfr_parse.sv
src/websocket_frame_receiver_top.sv
sim/tb_websocket_frame_receiver_top.sv
